// File: rtl/sctd_pkg.sv
// Shared constants, types and the CRC-8 byte update for the scratchpad decoder.
package sctd_pkg;

  // Frame layout: bytes 0 to 7 feed the CRC, byte 8 carries the received CRC
  localparam int unsigned IdxW       = 4;
  localparam logic [IdxW-1:0] CrcBytes = 4'd8;
  localparam logic [IdxW-1:0] IdxLow   = 4'd0;
  localparam logic [IdxW-1:0] IdxHigh  = 4'd1;

  // 1-Wire CRC-8, x^8+x^5+x^4+1, reflected
  localparam logic [7:0] CrcPoly = 8'h8C;

  // Depth of the queue between the byte front end and the result back end
  localparam int unsigned QueueDepth = 2;

  // One finished frame, handed from the front end to the back end
  typedef struct packed {
    logic [7:0] low_raw;
    logic [7:0] high_raw;
    logic [7:0] crc;
    logic       crc_error;
  } frame_job_t;

  // One byte of the reflected CRC-8: eight shift/xor steps on an 8-bit value
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/sctd_in_if.sv
// Input channel: one scratchpad byte per transfer.
interface sctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// File: rtl/sctd_out_if.sv
// Output channel: one decoded scratchpad result per transfer.
interface sctd_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] temp_tenths;
  logic               crc_error;
  logic        [7:0]  computed_crc;

  modport source (output valid, output temp_tenths, output crc_error, output computed_crc,
                  input ready);
  modport sink   (input valid, input temp_tenths, input crc_error, input computed_crc,
                  output ready);
endinterface

// File: rtl/sctd_front.sv
// Front end: byte counting, running CRC, raw byte capture and frame hand-off.
module sctd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_start_i,
  output logic                 in_ready_o,
  input  logic                 q_full_i,
  output logic                 push_o,
  output sctd_pkg::frame_job_t job_o
);
  import sctd_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      low_q, high_q;
  logic [IdxW-1:0] idx_eff;
  logic [7:0]      crc_base;
  logic            accept;
  logic            last_byte;

  // Byte is taken whenever the queue has room for a possible frame result
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // A frame start restarts the count and the CRC before this byte is used
  assign idx_eff   = frame_start_i ? IdxLow : idx_q;
  assign crc_base  = frame_start_i ? 8'h00 : crc_q;
  assign last_byte = (idx_eff >= CrcBytes);

  // Next count and CRC
  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    if (accept) begin
      if (last_byte) begin
        idx_d = IdxLow;
        crc_d = 8'h00;
      end else begin
        idx_d = idx_eff + IdxW'(1);
        crc_d = crc8_update(crc_base, data_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= IdxLow;
      crc_q <= 8'h00;
    end else begin
      idx_q <= idx_d;
      crc_q <= crc_d;
    end
  end

  // Raw temperature bytes 0 and 1
  always_ff @(posedge clk_i) begin
    if (accept && !last_byte && (idx_eff == IdxLow)) begin
      low_q <= data_byte_i;
    end
    if (accept && !last_byte && (idx_eff == IdxHigh)) begin
      high_q <= data_byte_i;
    end
  end

  // Byte 8 closes the frame and hands it to the queue
  assign push_o          = accept && last_byte;
  assign job_o.low_raw   = low_q;
  assign job_o.high_raw  = high_q;
  assign job_o.crc       = crc_base;
  assign job_o.crc_error = (crc_base != data_byte_i);

endmodule

// File: rtl/sctd_queue.sv
// Short register queue of finished frames between front and back end.
module sctd_queue #(
  parameter int unsigned Depth = sctd_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sctd_pkg::frame_job_t job_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output sctd_pkg::frame_job_t job_o
);
  import sctd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_job_t      slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/sctd_back.sv
// Back end: temperature conversion to tenths and the output register.
module sctd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  sctd_pkg::frame_job_t job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [11:0]   temp_tenths_o,
  output logic                 crc_error_o,
  output logic [7:0]           computed_crc_o
);
  import sctd_pkg::*;

  logic               valid_q;
  logic signed [11:0] temp_q;
  logic               err_q;
  logic [7:0]         crc_q;
  logic               load;

  logic        neg;
  logic [15:0] raw;
  logic [15:0] mag;
  logic [6:0]  int_part;
  logic [7:0]  frac_x10;
  logic [3:0]  tenths;
  logic [10:0] val;
  logic [11:0] temp_d;

  // Sign-magnitude split, integer part times ten, truncated tenths digit
  always_comb begin
    raw      = {job_i.high_raw, job_i.low_raw};
    neg      = job_i.high_raw[7];
    mag      = neg ? (~raw + 16'd1) : raw;
    int_part = {mag[10:8], mag[7:4]};
    frac_x10 = {1'b0, mag[3:0], 3'b000} + {3'b000, mag[3:0], 1'b0};
    tenths   = frac_x10[7:4];
    val      = {1'b0, int_part, 3'b000} + {3'b000, int_part, 1'b0} + {7'd0, tenths};
    temp_d   = neg ? (12'd0 - {1'b0, val}) : {1'b0, val};
  end

  // Output register refills when empty or when its result is taken
  assign load  = !q_empty_i && (!valid_q || out_ready_i);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      temp_q <= $signed(temp_d);
      err_q  <= job_i.crc_error;
      crc_q  <= job_i.crc;
    end
  end

  assign out_valid_o    = valid_q;
  assign temp_tenths_o  = temp_q;
  assign crc_error_o    = err_q;
  assign computed_crc_o = crc_q;

endmodule

// File: rtl/scratchpad_crc_temperature_decoder.sv
// Top level of the temperature scratchpad decoder with CRC-8 check.
//
// Channels: in_i takes one scratchpad byte per transfer (data_byte,
// frame_start); out_o gives one result per nine-byte frame (temp_tenths,
// crc_error, computed_crc). Both use valid/ready; a transfer happens when both
// are high at a rising clock edge.
// Throughput: one byte per cycle while in_i.ready is high, one result every
// nine bytes. The front end updates the CRC with one table-free byte step per
// accepted byte. Result path: byte 8 writes the finished frame into the frame
// queue, then the conversion/output register takes it and raises out_o.valid.
// A byte with frame_start high is byte 0 of a new frame; a partial frame is
// dropped without a result.
// Stall: when out_o.ready is low, up to QDepth finished frames wait in the
// queue and the output register holds its result; in_i.ready falls only when
// the queue is full, so bytes 0 to 7 of the next frame keep flowing meanwhile.
// Reset (rst_ni low, asynchronous): byte count and CRC clear, queue empties,
// no result is valid.
module scratchpad_crc_temperature_decoder #(
  parameter int unsigned QDepth = sctd_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sctd_in_if.sink    in_i,
  sctd_out_if.source out_o
);
  import sctd_pkg::*;

  frame_job_t push_job;
  frame_job_t pop_job;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;

  // Front end: accepts and classifies bytes
  sctd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .data_byte_i   (in_i.data_byte),
    .frame_start_i (in_i.frame_start),
    .in_ready_o    (in_i.ready),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Frame queue
  sctd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (pop_job)
  );

  // Back end: temperature conversion and output
  sctd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .job_i          (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .temp_tenths_o  (out_o.temp_tenths),
    .crc_error_o    (out_o.crc_error),
    .computed_crc_o (out_o.computed_crc)
  );

endmodule
